// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/spfm_pkg.sv
// ----------------------------------------------------------------------------
// Sprite pixel FIFO package
// Shared types, codes and helper functions of the object pixel mixer.
// ----------------------------------------------------------------------------
package spfm_pkg;

  localparam int unsigned FifoDepth = 8;
  localparam int unsigned CountW    = 4;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_MIX  = 1'b1;

  localparam logic REG_OBJ_PAL_ZERO = 1'b0;
  localparam logic REG_OBJ_PAL_ONE  = 1'b1;

  typedef struct packed {
    logic [1:0] shade;
    logic [5:0] obj;
    logic [1:0] cidx;
    logic       behind;
  } entry_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] row_low_byte;
    logic [7:0] row_high_byte;
    logic [7:0] object_x;
    logic       flip_horizontal;
    logic       palette_select;
    logic [5:0] object_index;
    logic       behind_background;
    logic [1:0] bg_color_index;
    logic [1:0] bg_shade;
  } item_t;

  typedef struct packed {
    logic capture;
    logic do_load;
    logic do_mix;
  } cmd_t;

  typedef struct packed {
    logic              kind;
    logic [CountW-1:0] count;
  } status_t;

  typedef struct packed {
    logic       we;
    logic       idx;
    logic [7:0] wdata;
  } cfg_t;

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = v[k];
    end
    return r;
  endfunction

  function automatic logic [1:0] pal_shade(input logic [7:0] pal, input logic [1:0] cidx);
    logic [1:0] s;
    case (cidx)
      2'd0: s = pal[1:0];
      2'd1: s = pal[3:2];
      2'd2: s = pal[5:4];
      2'd3: s = pal[7:6];
      default: s = pal[1:0];
    endcase
    return s;
  endfunction

endpackage

// File: rtl/spfm_in_if.sv
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying load and mix items.
// ----------------------------------------------------------------------------
interface spfm_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] row_low_byte;
  logic [7:0] row_high_byte;
  logic [7:0] object_x;
  logic       flip_horizontal;
  logic       palette_select;
  logic [5:0] object_index;
  logic       behind_background;
  logic [1:0] bg_color_index;
  logic [1:0] bg_shade;

  modport source (
    output valid, kind, row_low_byte, row_high_byte, object_x, flip_horizontal,
           palette_select, object_index, behind_background, bg_color_index, bg_shade,
    input  ready
  );
  modport sink (
    input  valid, kind, row_low_byte, row_high_byte, object_x, flip_horizontal,
           palette_select, object_index, behind_background, bg_color_index, bg_shade,
    output ready
  );
endinterface

// File: rtl/spfm_out_if.sv
// ----------------------------------------------------------------------------
// Output channel interface
// Valid/ready channel carrying mixed screen pixels.
// ----------------------------------------------------------------------------
interface spfm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] pixel_shade;
  logic       from_object;

  modport source (output valid, pixel_shade, from_object, input ready);
  modport sink (input valid, pixel_shade, from_object, output ready);
endinterface

// File: rtl/spfm_ctrl.sv
// ----------------------------------------------------------------------------
// Sprite pixel FIFO controller
// Sequences accept and execute steps and owns the output valid flag.
// ----------------------------------------------------------------------------
module spfm_ctrl import spfm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.kind == KIND_LOAD) begin
          cmd_o.do_load = 1'b1;
          state_d       = ST_IDLE;
        end else if (out_free) begin
          cmd_o.do_mix = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/spfm_datapath.sv
// ----------------------------------------------------------------------------
// Sprite pixel FIFO datapath
// Palette registers, item register, object FIFO with row merge and pixel mix.
// ----------------------------------------------------------------------------
module spfm_datapath import spfm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  output logic [7:0] cfg_rdata_o,
  input  item_t      item_i,
  input  cmd_t       cmd_i,
  output status_t    status_o,
  output logic [1:0] pixel_shade_o,
  output logic       from_object_o
);

  logic [7:0]        pal0_q, pal1_q;
  item_t             item_q;
  entry_t            fifo_q [FifoDepth];
  entry_t            fifo_d [FifoDepth];
  logic [CountW-1:0] count_q, count_d;
  logic [1:0]        shade_q, shade_d;
  logic              from_obj_q, from_obj_d;

  logic [7:0]        pal;
  logic [7:0]        lo_f, hi_f;
  logic [CountW-1:0] skip, used, made;
  logic [CountW-1:0] pos;
  logic [2:0]        bitn;
  entry_t            pix;
  entry_t            front;

  assign cfg_rdata_o = (cfg_i.idx == REG_OBJ_PAL_ONE) ? pal1_q : pal0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal0_q <= '0;
      pal1_q <= '0;
    end else if (cfg_i.we) begin
      if (cfg_i.idx == REG_OBJ_PAL_ZERO) begin
        pal0_q <= cfg_i.wdata;
      end else begin
        pal1_q <= cfg_i.wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
  end

  assign status_o.kind  = item_q.kind;
  assign status_o.count = count_q;

  always_comb begin
    pal  = item_q.palette_select ? pal1_q : pal0_q;
    lo_f = item_q.flip_horizontal ? flip8(item_q.row_low_byte) : item_q.row_low_byte;
    hi_f = item_q.flip_horizontal ? flip8(item_q.row_high_byte) : item_q.row_high_byte;
    if (item_q.object_x[7:3] == 5'd0) begin
      skip = 4'd8 - {1'b0, item_q.object_x[2:0]};
    end else begin
      skip = 4'd0;
    end
    used = (count_q >= skip) ? skip : count_q;
    made = used + (4'd8 - skip);
    front = fifo_q[0];

    fifo_d     = fifo_q;
    count_d    = count_q;
    shade_d    = shade_q;
    from_obj_d = from_obj_q;
    pos        = '0;
    bitn       = '0;
    pix        = '0;

    if (cmd_i.do_load) begin
      for (int i = 0; i < FifoDepth; i++) begin
        pos  = CountW'(i) + skip - used;
        bitn = 3'd7 - pos[2:0];
        pix.cidx   = {hi_f[bitn], lo_f[bitn]};
        pix.shade  = pal_shade(pal, pix.cidx);
        pix.obj    = item_q.object_index;
        pix.behind = item_q.behind_background;
        if (CountW'(i) < used) begin
          fifo_d[i] = fifo_q[i];
        end else if (CountW'(i) < made) begin
          if (CountW'(i) < count_q) begin
            if (pix.cidx == 2'd0) begin
              fifo_d[i] = fifo_q[i];
            end else if (fifo_q[i].cidx == 2'd0) begin
              fifo_d[i] = pix;
            end else if (fifo_q[i].obj <= pix.obj) begin
              fifo_d[i] = fifo_q[i];
            end else begin
              fifo_d[i] = pix;
            end
          end else begin
            fifo_d[i] = pix;
          end
        end
      end
      count_d = made;
    end

    if (cmd_i.do_mix) begin
      shade_d    = item_q.bg_shade;
      from_obj_d = 1'b0;
      if (count_q != '0) begin
        for (int i = 0; i < FifoDepth - 1; i++) begin
          fifo_d[i] = fifo_q[i+1];
        end
        count_d = count_q - 4'd1;
        if (front.cidx != 2'd0 && !(front.behind && item_q.bg_color_index != 2'd0)) begin
          shade_d    = front.shade;
          from_obj_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fifo_q     <= fifo_d;
    shade_q    <= shade_d;
    from_obj_q <= from_obj_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign pixel_shade_o = shade_q;
  assign from_object_o = from_obj_q;

endmodule

// File: rtl/sprite_pixel_fifo_merge_mix.sv
// ----------------------------------------------------------------------------
// Sprite pixel FIFO merge and mix, top level
// Each item has an accept step and an execute step; a mix waits in execute
// until the output is free. A mix result is valid in the cycle after its
// execute step; the sequencer takes no new item until the last one executed.
// Reset clears the palettes, the FIFO count and the output valid flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sprite_pixel_fifo_merge_mix import spfm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  spfm_in_if.sink           in_i,
  spfm_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  item_t      item;
  cmd_t       cmd;
  status_t    status;
  cfg_t       cfg;
  logic [7:0] cfg_rdata;

  assign pready    = 1'b1;
  assign cfg.we    = psel && penable && pwrite;
  assign cfg.idx   = paddr[2];
  assign cfg.wdata = pwdata[7:0];
  assign prdata    = {24'd0, cfg_rdata};

  assign item.kind              = in_i.kind;
  assign item.row_low_byte      = in_i.row_low_byte;
  assign item.row_high_byte     = in_i.row_high_byte;
  assign item.object_x          = in_i.object_x;
  assign item.flip_horizontal   = in_i.flip_horizontal;
  assign item.palette_select    = in_i.palette_select;
  assign item.object_index      = in_i.object_index;
  assign item.behind_background = in_i.behind_background;
  assign item.bg_color_index    = in_i.bg_color_index;
  assign item.bg_shade          = in_i.bg_shade;

  spfm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  spfm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cfg_rdata_o   (cfg_rdata),
    .item_i        (item),
    .cmd_i         (cmd),
    .status_o      (status),
    .pixel_shade_o (out_o.pixel_shade),
    .from_object_o (out_o.from_object)
  );

  `ASSERT_ALWAYS(a_count_max, clk_i, rst_ni, status.count <= 4'd8)
  `ASSERT_IMPLIES(a_mix_no_overwrite, clk_i, rst_ni, cmd.do_mix, !out_o.valid || out_o.ready)
  `ASSERT_NEXT(a_load_grows, clk_i, rst_ni, cmd.do_load, status.count >= $past(status.count))
  `ASSERT_NEXT(a_mix_pops, clk_i, rst_ni, cmd.do_mix && status.count != 4'd0, status.count == $past(status.count) - 4'd1)

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sprite pixel FIFO merge and mix testbench
// Sends load and mix transfers in random bursts while the pixel receiver
// stalls on its own pattern. A shadow copy of the object FIFO and of both
// palettes predicts every mixed pixel, and the pixels are checked in order.
// The palettes are rewritten between phases, while the block is idle.
// ---------------------------------------------------------------------------
module tb;
  import spfm_pkg::*;

  localparam int unsigned MaxCycles = 200000;

  typedef struct packed {
    logic [1:0] shade;
    logic       from_object;
  } pixel_t;

  logic        clk;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  spfm_in_if  in_ch ();
  spfm_out_if out_ch ();

  sprite_pixel_fifo_merge_mix dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [7:0]  pal_zero_q = 8'h00;
  logic [7:0]  pal_one_q  = 8'h00;
  entry_t      obj_fifo[FifoDepth];
  int unsigned obj_count  = 0;

  item_t       item_q[$];
  pixel_t      pixel_q[$];
  item_t       cur_item;
  pixel_t      want;
  int unsigned n_pushed   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_pixels   = 0;
  int unsigned n_errors   = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned burst_left = 8;
  int unsigned gap_left   = 0;
  int unsigned ready_run  = 0;
  int unsigned hold_left  = 0;
  logic        ready_level = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] mirror_byte(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

  function automatic void merge_row(input item_t it);
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  pal;
    entry_t      merged[FifoDepth];
    entry_t      px;
    entry_t      old;
    int unsigned skip;
    int unsigned used;
    int unsigned made;
    lo   = it.flip_horizontal ? mirror_byte(it.row_low_byte) : it.row_low_byte;
    hi   = it.flip_horizontal ? mirror_byte(it.row_high_byte) : it.row_high_byte;
    pal  = it.palette_select ? pal_one_q : pal_zero_q;
    skip = (it.object_x < 8) ? 8 - it.object_x : 0;
    used = 0;
    made = 0;
    for (int unsigned pos = 0; pos < 8; pos++) begin
      if (pos < skip) begin
        if (used < obj_count) begin
          merged[made] = obj_fifo[used];
          made++;
          used++;
        end
      end else begin
        px.cidx   = {hi[7-pos], lo[7-pos]};
        px.shade  = pal[2*px.cidx +: 2];
        px.obj    = it.object_index;
        px.behind = it.behind_background;
        if (used < obj_count) begin
          old = obj_fifo[used];
          used++;
          if (px.cidx == 2'd0 || (old.cidx != 2'd0 && old.obj <= px.obj)) begin
            merged[made] = old;
          end else begin
            merged[made] = px;
          end
        end else begin
          merged[made] = px;
        end
        made++;
      end
    end
    for (int unsigned k = 0; k < made; k++) begin
      obj_fifo[k] = merged[k];
    end
    obj_count = made;
  endfunction

  function automatic pixel_t mix_pixel(input item_t it);
    pixel_t res;
    entry_t front;
    res.shade       = it.bg_shade;
    res.from_object = 1'b0;
    if (obj_count > 0) begin
      front = obj_fifo[0];
      for (int unsigned k = 0; k + 1 < FifoDepth; k++) begin
        obj_fifo[k] = obj_fifo[k+1];
      end
      obj_count--;
      if (front.cidx != 2'd0 && !(front.behind && it.bg_color_index != 2'd0)) begin
        res.shade       = front.shade;
        res.from_object = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it.kind              = $urandom_range(0, 1) ? KIND_MIX : KIND_LOAD;
    it.row_low_byte      = 8'($urandom_range(0, 255));
    it.row_high_byte     = 8'($urandom_range(0, 255));
    it.object_x          = 8'($urandom_range(0, 255));
    it.flip_horizontal   = 1'($urandom_range(0, 1));
    it.palette_select    = 1'($urandom_range(0, 1));
    it.object_index      = 6'($urandom_range(0, 63));
    it.behind_background = 1'($urandom_range(0, 1));
    it.bg_color_index    = 2'($urandom_range(0, 3));
    it.bg_shade          = 2'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic void push_item(input item_t it);
    item_q.push_back(it);
    n_pushed++;
  endfunction

  function automatic void add_load(input logic [7:0] lo, input logic [7:0] hi,
                                   input logic [7:0] x, input logic flip,
                                   input logic pal, input logic [5:0] obj,
                                   input logic behind);
    item_t it;
    it                   = noise_item();
    it.kind              = KIND_LOAD;
    it.row_low_byte      = lo;
    it.row_high_byte     = hi;
    it.object_x          = x;
    it.flip_horizontal   = flip;
    it.palette_select    = pal;
    it.object_index      = obj;
    it.behind_background = behind;
    push_item(it);
  endfunction

  function automatic void add_mix(input logic [1:0] bg_idx, input logic [1:0] bg_sh);
    item_t it;
    it                = noise_item();
    it.kind           = KIND_MIX;
    it.bg_color_index = bg_idx;
    it.bg_shade       = bg_sh;
    push_item(it);
  endfunction

  task automatic random_phase(input int unsigned n_items);
    int unsigned start;
    logic [7:0]  x;
    logic [5:0]  obj;
    start = n_pushed;
    while (n_pushed - start < n_items) begin
      case ($urandom_range(0, 9))
        0: push_item(noise_item());
        1: repeat ($urandom_range(1, 6)) begin
          add_mix(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
        end
        default: begin
          repeat ($urandom_range(1, 4)) begin
            x   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 16));
            obj = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(40, 63))
                                              : 6'($urandom_range(0, 39));
            add_load(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), x,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), obj,
                     1'($urandom_range(0, 1)));
          end
          repeat ($urandom_range(4, 14)) begin
            add_mix(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
          end
        end
      endcase
    end
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_OBJ_PAL_ZERO) begin
      pal_zero_q = value;
    end else begin
      pal_one_q = value;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (n_accepted != n_pushed || pixel_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        n_accepted++;
        if (cur_item.kind == KIND_MIX) begin
          pixel_q.push_back(mix_pixel(cur_item));
        end else begin
          merge_row(cur_item);
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          in_ch.valid <= 1'b0;
          gap_left--;
        end else if (item_q.size() > 0) begin
          cur_item = item_q.pop_front();
          in_ch.kind              <= cur_item.kind;
          in_ch.row_low_byte      <= cur_item.row_low_byte;
          in_ch.row_high_byte     <= cur_item.row_high_byte;
          in_ch.object_x          <= cur_item.object_x;
          in_ch.flip_horizontal   <= cur_item.flip_horizontal;
          in_ch.palette_select    <= cur_item.palette_select;
          in_ch.object_index      <= cur_item.object_index;
          in_ch.behind_background <= cur_item.behind_background;
          in_ch.bg_color_index    <= cur_item.bg_color_index;
          in_ch.bg_shade          <= cur_item.bg_shade;
          in_ch.valid             <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end
          if (burst_left == 0) begin
            gap_left   = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_pixels++;
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel transfer: pixel_shade %0d from_object %0d",
                 out_ch.pixel_shade, out_ch.from_object);
          n_errors++;
        end else begin
          want = pixel_q.pop_front();
          if (out_ch.pixel_shade !== want.shade) begin
            $error("pixel_shade mismatch: expected %0d, actual %0d",
                   want.shade, out_ch.pixel_shade);
            n_errors++;
          end
          if (out_ch.from_object !== want.from_object) begin
            $error("from_object mismatch: expected %0d, actual %0d",
                   want.from_object, out_ch.from_object);
            n_errors++;
          end
        end
        if (n_pixels == 150 || n_pixels == 600) begin
          hold_left = 300;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (ready_run == 0) begin
          ready_level = !ready_level;
          if (ready_level) begin
            ready_run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                                    : $urandom_range(1, 12);
          end else begin
            ready_run = $urandom_range(1, 5);
          end
        end
        ready_run--;
        out_ch.ready <= ready_level;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > MaxCycles) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [7:0] pz;
    logic [7:0] po;
    rst_ni                  = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    in_ch.valid             = 1'b0;
    in_ch.kind              = KIND_LOAD;
    in_ch.row_low_byte      = '0;
    in_ch.row_high_byte     = '0;
    in_ch.object_x          = '0;
    in_ch.flip_horizontal   = 1'b0;
    in_ch.palette_select    = 1'b0;
    in_ch.object_index      = '0;
    in_ch.behind_background = 1'b0;
    in_ch.bg_color_index    = '0;
    in_ch.bg_shade          = '0;
    out_ch.ready            = 1'b0;
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;

    write_reg(REG_OBJ_PAL_ZERO, 8'hE4);
    write_reg(REG_OBJ_PAL_ONE, 8'h1B);
    add_mix(2'd3, 2'd2);
    add_load(8'hFF, 8'h00, 8'd8, 1'b0, 1'b0, 6'd5, 1'b0);
    add_load(8'hAA, 8'h55, 8'd8, 1'b0, 1'b1, 6'd5, 1'b0);
    add_load(8'hFF, 8'hFF, 8'd0, 1'b0, 1'b0, 6'd0, 1'b0);
    add_load(8'hFF, 8'hFF, 8'd3, 1'b1, 1'b1, 6'd2, 1'b1);
    add_load(8'h80, 8'h01, 8'd255, 1'b1, 1'b0, 6'd63, 1'b0);
    add_mix(2'd0, 2'd3);
    add_mix(2'd1, 2'd0);
    add_mix(2'd3, 2'd3);
    add_mix(2'd2, 2'd1);
    add_load(8'h00, 8'h00, 8'd7, 1'b0, 1'b0, 6'd40, 1'b1);
    add_load(8'h0F, 8'hF0, 8'd8, 1'b1, 1'b1, 6'd39, 1'b0);
    repeat (5) add_mix(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
    add_load(8'hFF, 8'hFF, 8'd8, 1'b0, 1'b1, 6'd0, 1'b1);
    add_mix(2'd0, 2'd1);
    add_mix(2'd2, 2'd1);
    add_load(8'h3C, 8'hC3, 8'd1, 1'b0, 1'b0, 6'd20, 1'b1);
    add_load(8'h81, 8'h7E, 8'd9, 1'b0, 1'b1, 6'd3, 1'b0);
    repeat (3) add_mix(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      pz = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      po = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom_range(0, 255));
      write_reg(REG_OBJ_PAL_ZERO, pz);
      write_reg(REG_OBJ_PAL_ONE, po);
      random_phase(280);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (n_errors == 0 && pixel_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
